// ===== rtl/slpg_pkg.sv =====
// ----------------------------------------------------------------------------
// slpg_pkg
// Shared codes, constants, command/status bundles and the working palette
// for the status light pattern generator.
// ----------------------------------------------------------------------------
package slpg_pkg;

  // input word kinds (carried on tuser)
  localparam logic [1:0] ACT_TICK     = 2'd0;
  localparam logic [1:0] ACT_SET      = 2'd1;
  localparam logic [1:0] ACT_ACTIVITY = 2'd2;
  localparam logic [1:0] ACT_LINK     = 2'd3;

  // signal modes
  localparam logic [2:0] MODE_IDLE      = 3'd0;
  localparam logic [2:0] MODE_WORKING   = 3'd1;
  localparam logic [2:0] MODE_ATTENTION = 3'd2;
  localparam logic [2:0] MODE_BLOCKED   = 3'd3;
  localparam logic [2:0] MODE_COMPLETE  = 3'd4;
  localparam logic [2:0] MODE_OFF       = 3'd5;

  // colors, R in 23:16, G 15:8, B 7:0
  localparam logic [23:0] COLOR_WORK_GREEN = 24'h00FF20;
  localparam logic [23:0] COLOR_AMBER      = 24'hFFD000;
  localparam logic [23:0] COLOR_WORK_RED   = 24'hFF1800;
  localparam logic [23:0] COLOR_IDLE_GREEN = 24'h00FF18;
  localparam logic [23:0] COLOR_BREATH     = 24'h0060FF;
  localparam logic [23:0] COLOR_RED        = 24'hFF0000;

  // timing constants, all in ms
  localparam logic [4:0]  FRAME_MS     = 5'd20;
  localparam logic [13:0] QUIET_LIMIT  = 14'd15000;
  localparam logic [10:0] PHASE_LAST   = 11'd1799;
  localparam logic [31:0] COMPLETE_MS  = 32'd1400;
  localparam logic [10:0] SEG_MS       = 11'd1500;
  localparam logic [12:0] WORK_LAST    = 13'd4499;
  localparam logic [12:0] WORK_OFFSET  = 13'd2250;
  // elapsed value at which elapsed + offset wraps to zero in 32 bits
  localparam logic [31:0] OFFSET_WRAP  = 32'hFFFF_F736;
  localparam logic [9:0]  ATTN_LAST    = 10'd899;
  localparam logic [9:0]  ATTN_ON      = 10'd500;
  localparam logic [10:0] BLOCK_LAST   = 11'd1099;
  localparam logic [8:0]  DONE_LAST    = 9'd499;
  localparam logic [8:0]  DONE_ON      = 9'd220;

  // reciprocals: x/1500 = (x*R)>>29 for x < 2^19; x/60 = (x*R)>>18 for x < 4681
  localparam logic [18:0] DIV1500_RECIP = 19'd357914;
  localparam logic [12:0] DIV60_RECIP   = 13'd4370;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SEL,
    ST_MIX,
    ST_DIV,
    ST_SCALE,
    ST_STORE,
    ST_CMP
  } slpg_state_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;   // capture the accepted input word
    logic apply;     // update timers and mode from the held word
    logic store;     // write a finished LED color
    logic publish;   // compare with shown colors and emit on change
    logic led;       // LED under work
  } slpg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_due;  // the held word is a tick that renders a frame
    logic out_busy;   // output register full and not being taken
  } slpg_status_t;

  // working blend palette
  function automatic logic [23:0] work_palette(input logic [1:0] idx);
    logic [23:0] c;
    case (idx)
      2'd0:    c = COLOR_WORK_GREEN;
      2'd1:    c = COLOR_AMBER;
      2'd2:    c = COLOR_WORK_RED;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/status_light_pattern_generator.sv =====
// ----------------------------------------------------------------------------
// status_light_pattern_generator
// Two-LED status light: mode-driven blink, blend and breathing patterns,
// rendered every 20 ticks; emitted on a color or mode change or brightness write.
//
//   channel      | direction | contents
//   -------------+-----------+-------------------------------------------------
//   s_axis       | in        | tuser: action; tdata: new_mode, link_up
//   m_axis       | out       | tdata: first_color, second_color
//   brightness_* | in        | level write, taken whenever wr_en is high
//
// A non-rendering word goes through accept and apply. A rendering tick goes
// through accept, apply, five arithmetic steps per LED run twice over a
// three-lane blend/divide/scale pipeline, then a compare-and-publish step.
// Reset is synchronous; brightness returns to 64 and nothing is shown.
// The output register holds a word while m_axis_tready is low; the next input
// is still accepted, and a new frame waits only if the register is still full.
// ----------------------------------------------------------------------------
module status_light_pattern_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,       // [2:0] new_mode, [3] link_up, [7:4] zero
  input  logic [1:0]  s_axis_tuser,       // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,       // [23:0] first_color, [47:24] second_color
  input  logic        brightness_wr_en,
  input  logic [7:0]  brightness_wr_data
);

  slpg_pkg::slpg_cmd_t    cmd;
  slpg_pkg::slpg_status_t status;

  // sequencer
  slpg_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  // timers, color math and output register
  slpg_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .s_axis_tdata       (s_axis_tdata),
    .s_axis_tuser       (s_axis_tuser),
    .brightness_wr_en   (brightness_wr_en),
    .brightness_wr_data (brightness_wr_data),
    .m_axis_tvalid      (m_axis_tvalid),
    .m_axis_tready      (m_axis_tready),
    .m_axis_tdata       (m_axis_tdata)
  );

endmodule

// ===== rtl/slpg_ctrl.sv =====
// ----------------------------------------------------------------------------
// slpg_ctrl
// Sequencer: accepts and applies a word; for a rendering tick it walks
// both LEDs through select/mix/divide/scale/store and publishes the frame.
// ----------------------------------------------------------------------------
module slpg_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  slpg_pkg::slpg_status_t status,
  output slpg_pkg::slpg_cmd_t    cmd
);

  slpg_pkg::slpg_state_t state, state_next;
  logic                  led, led_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slpg_pkg::ST_IDLE;
      led   <= 1'b0;
    end else begin
      state <= state_next;
      led   <= led_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    led_next      = led;
    s_axis_tready = 1'b0;
    cmd           = '0;
    cmd.led       = led;
    case (state)
      slpg_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = slpg_pkg::ST_APPLY;
        end
      end
      slpg_pkg::ST_APPLY: begin
        cmd.apply = 1'b1;
        if (status.frame_due) begin
          led_next   = 1'b0;
          state_next = slpg_pkg::ST_SEL;
        end else begin
          state_next = slpg_pkg::ST_IDLE;
        end
      end
      slpg_pkg::ST_SEL:   state_next = slpg_pkg::ST_MIX;
      slpg_pkg::ST_MIX:   state_next = slpg_pkg::ST_DIV;
      slpg_pkg::ST_DIV:   state_next = slpg_pkg::ST_SCALE;
      slpg_pkg::ST_SCALE: state_next = slpg_pkg::ST_STORE;
      slpg_pkg::ST_STORE: begin
        cmd.store = 1'b1;
        if (led) begin
          state_next = slpg_pkg::ST_CMP;
        end else begin
          led_next   = 1'b1;
          state_next = slpg_pkg::ST_SEL;
        end
      end
      slpg_pkg::ST_CMP: begin
        // hold until the output register can take a new word
        if (!status.out_busy) begin
          cmd.publish = 1'b1;
          state_next  = slpg_pkg::ST_IDLE;
        end
      end
      default: state_next = slpg_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/slpg_datapath.sv =====
// ----------------------------------------------------------------------------
// slpg_datapath
// Timers, mode state, color selection, three-lane blend/scale arithmetic,
// shown-color memory and the output register.
// ----------------------------------------------------------------------------
module slpg_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  slpg_pkg::slpg_cmd_t    cmd,
  output slpg_pkg::slpg_status_t status,
  input  logic [7:0]             s_axis_tdata,
  input  logic [1:0]             s_axis_tuser,
  input  logic                   brightness_wr_en,
  input  logic [7:0]             brightness_wr_data,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [47:0]            m_axis_tdata
);

  // held input word
  logic [1:0]  act_q;
  logic [2:0]  mode_in_q;
  logic        link_in_q;

  // control state
  logic [7:0]  brightness;
  logic [2:0]  signal_mode, signal_mode_next;
  logic [31:0] mode_elapsed, mode_elapsed_next;
  logic [13:0] quiet_time, quiet_time_next;
  logic        link_connected, link_connected_next;
  logic [10:0] wait_phase, wait_phase_next;
  logic [4:0]  frame_age, frame_age_next;
  logic        shown_valid, shown_valid_next;
  // positions of elapsed time within each pattern period
  logic [12:0] pos_a, pos_a_next;      // elapsed mod 4500
  logic [12:0] pos_b, pos_b_next;      // (elapsed + 2250) mod 4500
  logic [9:0]  cnt_attn, cnt_attn_next;
  logic [10:0] cnt_block, cnt_block_next;
  logic [8:0]  cnt_done, cnt_done_next;

  // tick helpers
  logic [31:0] elapsed_inc;
  logic        complete_done;
  logic [4:0]  age_tick;
  logic        tick_held;

  // pipeline
  logic [23:0] sel_x, sel_y, sel_x_next, sel_y_next;
  logic [10:0] sel_w, sel_w_next;
  logic [7:0]  sel_lvl, sel_lvl_next;
  logic [18:0] mix_v [3];
  logic [7:0]  mix_lvl;
  logic [7:0]  div_q [3];
  logic [7:0]  div_lvl;
  logic [15:0] scale_p [3];
  logic [23:0] done_color;
  logic [23:0] color0, color1;
  logic [23:0] shown0, shown1;
  logic        differs;

  // ---------------------------------------------------------------
  // tick bookkeeping shared by state update and frame decision
  always_comb begin
    tick_held     = (act_q == slpg_pkg::ACT_TICK);
    elapsed_inc   = mode_elapsed + 32'd1;
    complete_done = (signal_mode == slpg_pkg::MODE_COMPLETE) &&
                    (elapsed_inc >= slpg_pkg::COMPLETE_MS);
    if (complete_done) begin
      age_tick = slpg_pkg::FRAME_MS;
    end else if (frame_age < slpg_pkg::FRAME_MS) begin
      age_tick = frame_age + 5'd1;
    end else begin
      age_tick = frame_age;
    end
  end

  assign status.frame_due = tick_held && (age_tick >= slpg_pkg::FRAME_MS);
  assign status.out_busy  = m_axis_tvalid && !m_axis_tready;
  assign differs = !shown_valid || (color0 != shown0) || (color1 != shown1);

  // ---------------------------------------------------------------
  // next state of timers and mode
  always_comb begin
    signal_mode_next    = signal_mode;
    mode_elapsed_next   = mode_elapsed;
    quiet_time_next     = quiet_time;
    link_connected_next = link_connected;
    wait_phase_next     = wait_phase;
    frame_age_next      = frame_age;
    shown_valid_next    = shown_valid;
    pos_a_next          = pos_a;
    pos_b_next          = pos_b;
    cnt_attn_next       = cnt_attn;
    cnt_block_next      = cnt_block;
    cnt_done_next       = cnt_done;
    if (cmd.apply) begin
      case (act_q)
        slpg_pkg::ACT_SET: begin
          // codes six and seven are ignored
          if (mode_in_q <= slpg_pkg::MODE_OFF) begin
            signal_mode_next  = mode_in_q;
            mode_elapsed_next = 32'd0;
            quiet_time_next   = 14'd0;
            frame_age_next    = slpg_pkg::FRAME_MS;
            shown_valid_next  = 1'b0;
            pos_a_next        = 13'd0;
            pos_b_next        = slpg_pkg::WORK_OFFSET;
            cnt_attn_next     = 10'd0;
            cnt_block_next    = 11'd0;
            cnt_done_next     = 9'd0;
          end
        end
        slpg_pkg::ACT_ACTIVITY: quiet_time_next = 14'd0;
        slpg_pkg::ACT_LINK: begin
          link_connected_next = link_in_q;
          quiet_time_next     = 14'd0;
        end
        default: begin
          // one millisecond tick
          mode_elapsed_next = elapsed_inc;
          if (quiet_time < slpg_pkg::QUIET_LIMIT) quiet_time_next = quiet_time + 14'd1;
          wait_phase_next = (wait_phase == slpg_pkg::PHASE_LAST) ? 11'd0 : wait_phase + 11'd1;
          // elapsed wrapping to zero restarts the periods
          if (elapsed_inc == 32'd0) begin
            pos_a_next     = 13'd0;
            cnt_attn_next  = 10'd0;
            cnt_block_next = 11'd0;
            cnt_done_next  = 9'd0;
          end else begin
            pos_a_next     = (pos_a == slpg_pkg::WORK_LAST) ? 13'd0 : pos_a + 13'd1;
            cnt_attn_next  = (cnt_attn == slpg_pkg::ATTN_LAST) ? 10'd0 : cnt_attn + 10'd1;
            cnt_block_next = (cnt_block == slpg_pkg::BLOCK_LAST) ? 11'd0 : cnt_block + 11'd1;
            cnt_done_next  = (cnt_done == slpg_pkg::DONE_LAST) ? 9'd0 : cnt_done + 9'd1;
          end
          if (elapsed_inc == slpg_pkg::OFFSET_WRAP) begin
            pos_b_next = 13'd0;
          end else begin
            pos_b_next = (pos_b == slpg_pkg::WORK_LAST) ? 13'd0 : pos_b + 13'd1;
          end
          // complete falls back to idle, quiet time kept
          if (complete_done) begin
            signal_mode_next  = slpg_pkg::MODE_IDLE;
            mode_elapsed_next = 32'd0;
            shown_valid_next  = 1'b0;
            pos_a_next        = 13'd0;
            pos_b_next        = slpg_pkg::WORK_OFFSET;
            cnt_attn_next     = 10'd0;
            cnt_block_next    = 11'd0;
            cnt_done_next     = 9'd0;
          end
          frame_age_next = (age_tick >= slpg_pkg::FRAME_MS) ? 5'd0 : age_tick;
        end
      endcase
    end
    if (cmd.publish && differs) shown_valid_next = 1'b1;
    if (brightness_wr_en) shown_valid_next = 1'b0;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness     <= 8'd64;
      signal_mode    <= slpg_pkg::MODE_IDLE;
      mode_elapsed   <= 32'd0;
      quiet_time     <= 14'd0;
      link_connected <= 1'b0;
      wait_phase     <= 11'd0;
      frame_age      <= 5'd0;
      shown_valid    <= 1'b0;
      pos_a          <= 13'd0;
      pos_b          <= slpg_pkg::WORK_OFFSET;
      cnt_attn       <= 10'd0;
      cnt_block      <= 11'd0;
      cnt_done       <= 9'd0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (brightness_wr_en) brightness <= brightness_wr_data;
      signal_mode    <= signal_mode_next;
      mode_elapsed   <= mode_elapsed_next;
      quiet_time     <= quiet_time_next;
      link_connected <= link_connected_next;
      wait_phase     <= wait_phase_next;
      frame_age      <= frame_age_next;
      shown_valid    <= shown_valid_next;
      pos_a          <= pos_a_next;
      pos_b          <= pos_b_next;
      cnt_attn       <= cnt_attn_next;
      cnt_block      <= cnt_block_next;
      cnt_done       <= cnt_done_next;
      if (cmd.publish && differs) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------
  // select step: blend endpoints, weight and level for one LED
  always_comb begin
    logic        breathing;
    logic [12:0] pos;
    logic [1:0]  seg;
    logic [1:0]  seg_nxt;
    logic [12:0] seg_base;
    logic [10:0] ph_off;
    logic [11:0] bx;
    logic [24:0] bprod;
    logic [5:0]  bq;
    logic [5:0]  breath;
    logic        blk_on;

    breathing = !link_connected && quiet_time >= slpg_pkg::QUIET_LIMIT &&
                (signal_mode == slpg_pkg::MODE_IDLE || signal_mode == slpg_pkg::MODE_OFF);

    // working segment and position within it
    pos = cmd.led ? pos_b : pos_a;
    if (pos >= 13'd3000) begin
      seg      = 2'd2;
      seg_base = 13'd3000;
    end else if (pos >= 13'd1500) begin
      seg      = 2'd1;
      seg_base = 13'd1500;
    end else begin
      seg      = 2'd0;
      seg_base = 13'd0;
    end
    seg_nxt = (seg == 2'd2) ? 2'd0 : seg + 2'd1;

    // breathing level: ramp up over 300 ms, down over 300 ms, then floor
    ph_off = (wait_phase < 11'd300) ? wait_phase : wait_phase - 11'd300;
    bx     = 12'(ph_off) * 12'd7;
    bprod  = 25'(bx) * 25'(slpg_pkg::DIV60_RECIP);
    bq     = bprod[23:18];
    if (wait_phase < 11'd300) begin
      breath = 6'd5 + bq;
    end else if (wait_phase < 11'd600) begin
      breath = 6'd40 - bq;
    end else begin
      breath = 6'd5;
    end

    blk_on = (cnt_block < 11'd140) || (cnt_block >= 11'd260 && cnt_block < 11'd400);

    sel_x_next   = 24'h000000;
    sel_y_next   = 24'h000000;
    sel_w_next   = 11'd0;
    sel_lvl_next = brightness;
    if (breathing) begin
      sel_lvl_next = 8'(breath);
      if (!cmd.led || wait_phase >= 11'd900) sel_x_next = slpg_pkg::COLOR_BREATH;
    end else begin
      case (signal_mode)
        slpg_pkg::MODE_IDLE: sel_x_next = slpg_pkg::COLOR_IDLE_GREEN;
        slpg_pkg::MODE_WORKING: begin
          sel_x_next = slpg_pkg::work_palette(seg);
          sel_y_next = slpg_pkg::work_palette(seg_nxt);
          sel_w_next = 11'(pos - seg_base);
        end
        slpg_pkg::MODE_ATTENTION:
          if (cnt_attn < slpg_pkg::ATTN_ON) sel_x_next = slpg_pkg::COLOR_AMBER;
        slpg_pkg::MODE_BLOCKED:
          if (blk_on) sel_x_next = slpg_pkg::COLOR_RED;
        slpg_pkg::MODE_COMPLETE:
          if (cnt_done < slpg_pkg::DONE_ON) sel_x_next = slpg_pkg::COLOR_IDLE_GREEN;
        default: sel_x_next = 24'h000000;
      endcase
    end
  end

  // arithmetic pipeline, one lane per color channel (lane 2 red .. lane 0 blue)
  always_comb begin
    logic [16:0] rnd;
    done_color = 24'h000000;
    for (int i = 0; i < 3; i++) begin
      // divide by 255 exactly: (p + 1 + p/256) / 256
      rnd = 17'(scale_p[i]) + 17'd1 + 17'(scale_p[i][15:8]);
      done_color[8*i +: 8] = rnd[15:8];
    end
  end

  always_ff @(posedge clk) begin
    logic [10:0] w_inv;
    logic [37:0] dprod;
    if (cmd.load_in) begin
      act_q     <= s_axis_tuser;
      mode_in_q <= s_axis_tdata[2:0];
      link_in_q <= s_axis_tdata[3];
    end
    // select
    sel_x   <= sel_x_next;
    sel_y   <= sel_y_next;
    sel_w   <= sel_w_next;
    sel_lvl <= sel_lvl_next;
    // blend: x*(1500-w) + y*w
    w_inv   = slpg_pkg::SEG_MS - sel_w;
    mix_lvl <= sel_lvl;
    for (int i = 0; i < 3; i++) begin
      mix_v[i] <= 19'(sel_x[8*i +: 8]) * 19'(w_inv) + 19'(sel_y[8*i +: 8]) * 19'(sel_w);
    end
    // divide by 1500
    div_lvl <= mix_lvl;
    for (int i = 0; i < 3; i++) begin
      dprod     = 38'(mix_v[i]) * 38'(slpg_pkg::DIV1500_RECIP);
      div_q[i] <= dprod[36:29];
    end
    // scale by level
    for (int i = 0; i < 3; i++) begin
      scale_p[i] <= 16'(div_q[i]) * 16'(div_lvl);
    end
    // store finished LED color
    if (cmd.store) begin
      if (cmd.led) begin
        color1 <= done_color;
      end else begin
        color0 <= done_color;
      end
    end
    // publish on change
    if (cmd.publish && differs) begin
      shown0       <= color0;
      shown1       <= color1;
      m_axis_tdata <= {color1, color0};
    end
  end

endmodule

// ===== tb/sv/status_light_pattern_generator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// status_light_pattern_generator_test
// Self-checking bench for the two-LED status light generator. Words go in on
// the input stream with random gaps. A local model of the timers, modes,
// blend and breathing patterns predicts each emitted color pair. Emitted
// words are checked field by field against the oldest prediction while the
// output side stalls at random.
// ----------------------------------------------------------------------------
module status_light_pattern_generator_test;

  localparam int unsigned CYCLE_LIMIT    = 6000000;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned RANDOM_WORDS   = 80;
  localparam int unsigned MAX_PRINTS     = 100;
  // breathing envelope, in ms of phase and levels out of 255
  localparam int unsigned BREATH_RISE    = 300;
  localparam int unsigned BREATH_FALL    = 600;
  localparam int unsigned BREATH_SPLIT   = 900;
  localparam int unsigned BREATH_SPAN    = 35;
  localparam int unsigned BREATH_FLOOR   = 5;
  localparam int unsigned BREATH_PEAK    = 40;
  // blocked double flash, in ms of the period
  localparam int unsigned FLASH_ONE_END  = 140;
  localparam int unsigned FLASH_TWO_BEG  = 260;
  localparam int unsigned FLASH_TWO_END  = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;       // [2:0] new_mode, [3] link_up, [7:4] zero
  logic [1:0]  s_axis_tuser = '0;       // [1:0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [47:0] m_axis_tdata;            // [23:0] first_color, [47:24] second_color
  logic        brightness_wr_en = 1'b0;
  logic [7:0]  brightness_wr_data = '0;

  status_light_pattern_generator dut (
    .clk                (clk),
    .rst                (rst),
    .s_axis_tvalid      (s_axis_tvalid),
    .s_axis_tready      (s_axis_tready),
    .s_axis_tdata       (s_axis_tdata),
    .s_axis_tuser       (s_axis_tuser),
    .m_axis_tvalid      (m_axis_tvalid),
    .m_axis_tready      (m_axis_tready),
    .m_axis_tdata       (m_axis_tdata),
    .brightness_wr_en   (brightness_wr_en),
    .brightness_wr_data (brightness_wr_data)
  );

  // model state
  logic [7:0]  level_reg    = 8'd64;
  logic [2:0]  cur_mode     = slpg_pkg::MODE_IDLE;
  logic [31:0] mode_ms      = '0;
  logic [13:0] quiet_ms     = '0;
  logic        link_seen    = 1'b0;
  logic [10:0] breath_phase = '0;
  logic [4:0]  frame_ms     = '0;
  logic [47:0] shown_pair   = '0;
  logic        shown_ok     = 1'b0;

  logic [23:0] blend_stops [3] = '{slpg_pkg::COLOR_WORK_GREEN, slpg_pkg::COLOR_AMBER,
                                   slpg_pkg::COLOR_WORK_RED};

  logic [47:0] expected_colors [$];
  logic [47:0] want_colors;
  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  logic        idle_on     = 1'b1;

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- model
  function automatic logic [23:0] scale_color(input logic [23:0] c, input int unsigned lvl);
    logic [23:0] s;
    for (int k = 0; k < 3; k++)
      s[8*k +: 8] = 8'((32'(c[8*k +: 8]) * lvl) / 255);
    return s;
  endfunction

  function automatic logic [23:0] blend_color(input logic [23:0] a, input logic [23:0] b,
                                              input int unsigned w);
    logic [23:0] m;
    int unsigned seg_len;
    seg_len = 32'(slpg_pkg::SEG_MS);
    for (int k = 0; k < 3; k++)
      m[8*k +: 8] = 8'((32'(a[8*k +: 8]) * (seg_len - w) + 32'(b[8*k +: 8]) * w) / seg_len);
    return m;
  endfunction

  function automatic logic [23:0] work_color(input logic [31:0] t);
    int unsigned p;
    int unsigned seg;
    p   = t % (32'(slpg_pkg::WORK_LAST) + 32'd1);
    seg = p / 32'(slpg_pkg::SEG_MS);
    return blend_color(blend_stops[2'(seg)], blend_stops[2'((seg + 1) % 3)],
                       p % 32'(slpg_pkg::SEG_MS));
  endfunction

  // {second, first} for the current state
  function automatic logic [47:0] render_frame();
    logic [23:0] a;
    logic [23:0] b;
    int unsigned ph;
    int unsigned breath;
    int unsigned p;
    if (!link_seen &&
        (cur_mode == slpg_pkg::MODE_IDLE || cur_mode == slpg_pkg::MODE_OFF) &&
        quiet_ms >= slpg_pkg::QUIET_LIMIT) begin
      ph = 32'(breath_phase);
      breath = BREATH_FLOOR;
      if (ph < BREATH_RISE)
        breath = BREATH_FLOOR + (ph * BREATH_SPAN) / BREATH_RISE;
      else if (ph < BREATH_FALL)
        breath = BREATH_PEAK - ((ph - BREATH_RISE) * BREATH_SPAN) / BREATH_RISE;
      a = scale_color(slpg_pkg::COLOR_BREATH, breath);
      b = (ph >= BREATH_SPLIT) ? a : 24'h000000;
      return {b, a};
    end
    a = 24'h000000;
    b = 24'h000000;
    case (cur_mode)
      slpg_pkg::MODE_IDLE: begin
        a = scale_color(slpg_pkg::COLOR_IDLE_GREEN, 32'(level_reg));
        b = a;
      end
      slpg_pkg::MODE_WORKING: begin
        a = scale_color(work_color(mode_ms), 32'(level_reg));
        b = scale_color(work_color(mode_ms + 32'(slpg_pkg::WORK_OFFSET)), 32'(level_reg));
      end
      slpg_pkg::MODE_ATTENTION: begin
        if ((mode_ms % (32'(slpg_pkg::ATTN_LAST) + 32'd1)) < 32'(slpg_pkg::ATTN_ON))
          a = scale_color(slpg_pkg::COLOR_AMBER, 32'(level_reg));
        b = a;
      end
      slpg_pkg::MODE_BLOCKED: begin
        p = mode_ms % (32'(slpg_pkg::BLOCK_LAST) + 32'd1);
        if (p < FLASH_ONE_END || (p >= FLASH_TWO_BEG && p < FLASH_TWO_END))
          a = scale_color(slpg_pkg::COLOR_RED, 32'(level_reg));
        b = a;
      end
      slpg_pkg::MODE_COMPLETE: begin
        if ((mode_ms % (32'(slpg_pkg::DONE_LAST) + 32'd1)) < 32'(slpg_pkg::DONE_ON))
          a = scale_color(slpg_pkg::COLOR_IDLE_GREEN, 32'(level_reg));
        b = a;
      end
      default: ;
    endcase
    return {b, a};
  endfunction

  task automatic enter_mode(input logic [2:0] md);
    cur_mode = md;
    mode_ms  = '0;
    frame_ms = slpg_pkg::FRAME_MS;
    shown_ok = 1'b0;
  endtask

  // update the model for one accepted word, queue the colors it emits
  task automatic advance_model(input logic [1:0] act, input logic [2:0] md, input logic lk);
    logic [47:0] pair;
    case (act)
      slpg_pkg::ACT_SET: begin
        if (md <= slpg_pkg::MODE_OFF) begin
          enter_mode(md);
          quiet_ms = '0;
        end
      end
      slpg_pkg::ACT_ACTIVITY: quiet_ms = '0;
      slpg_pkg::ACT_LINK: begin
        link_seen = lk;
        quiet_ms  = '0;
      end
      default: begin
        mode_ms = mode_ms + 32'd1;
        if (quiet_ms < slpg_pkg::QUIET_LIMIT) quiet_ms = quiet_ms + 14'd1;
        breath_phase = (breath_phase == slpg_pkg::PHASE_LAST) ? 11'd0 : breath_phase + 11'd1;
        if (frame_ms < slpg_pkg::FRAME_MS) frame_ms = frame_ms + 5'd1;
        // complete times out to idle
        if (cur_mode == slpg_pkg::MODE_COMPLETE && mode_ms >= slpg_pkg::COMPLETE_MS)
          enter_mode(slpg_pkg::MODE_IDLE);
        if (frame_ms == slpg_pkg::FRAME_MS) begin
          frame_ms = '0;
          pair = render_frame();
          if (!shown_ok || pair != shown_pair) begin
            shown_pair = pair;
            shown_ok   = 1'b1;
            expected_colors.push_back(pair);
          end
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------- drivers
  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic send_word(input logic [1:0] act, input logic [2:0] md, input logic lk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {4'b0000, lk, md};
    do @(posedge clk); while (!s_axis_tready);
    advance_model(act, md, lk);
  endtask

  // ticks carry random content in the unused fields
  task automatic run_ticks(input int unsigned n);
    repeat (n) send_word(slpg_pkg::ACT_TICK, 3'($urandom_range(0, 7)),
                         1'($urandom_range(0, 1)));
  endtask

  // stop sending, drain every expected word, then let the block go quiet
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_brightness(input logic [7:0] lvl);
    settle_block();
    brightness_wr_en   <= 1'b1;
    brightness_wr_data <= lvl;
    @(posedge clk);
    brightness_wr_en   <= 1'b0;
    level_reg = lvl;
    shown_ok  = 1'b0;
  endtask

  // ---------------------------------------------------------------- tests
  // first frame after reset: idle green at the reset level
  task automatic test_reset_state();
    run_ticks(25);
  endtask

  // every mode, both ignored mode codes, activity and link words
  task automatic test_directed();
    send_word(slpg_pkg::ACT_SET, slpg_pkg::MODE_WORKING, 1'b1);
    run_ticks(1);
    send_word(slpg_pkg::ACT_SET, slpg_pkg::MODE_ATTENTION, 1'b0);
    run_ticks(1);
    send_word(slpg_pkg::ACT_SET, slpg_pkg::MODE_BLOCKED, 1'b0);
    run_ticks(1);
    send_word(slpg_pkg::ACT_SET, slpg_pkg::MODE_COMPLETE, 1'b1);
    run_ticks(1);
    send_word(slpg_pkg::ACT_SET, slpg_pkg::MODE_OFF, 1'b0);
    run_ticks(1);
    send_word(slpg_pkg::ACT_SET, 3'd6, 1'b1);
    run_ticks(1);
    send_word(slpg_pkg::ACT_SET, 3'd7, 1'b0);
    send_word(slpg_pkg::ACT_ACTIVITY, 3'd7, 1'b1);
    send_word(slpg_pkg::ACT_LINK, 3'd0, 1'b1);
    send_word(slpg_pkg::ACT_LINK, 3'd5, 1'b1);   // same level again
    send_word(slpg_pkg::ACT_LINK, 3'd2, 1'b0);
    send_word(slpg_pkg::ACT_SET, slpg_pkg::MODE_IDLE, 1'b1);
    run_ticks(3);
    send_word(slpg_pkg::ACT_SET, slpg_pkg::MODE_WORKING, 1'b0);
    run_ticks(22);
  endtask

  // level extremes scale every channel
  task automatic test_brightness_levels();
    logic [7:0] lvl;
    for (int i = 0; i < 4; i++) begin
      case (i)
        0:       lvl = 8'd1;
        1:       lvl = 8'd255;
        2:       lvl = 8'($urandom_range(2, 254));
        default: lvl = 8'd128;
      endcase
      write_brightness(lvl);
      send_word(slpg_pkg::ACT_SET, slpg_pkg::MODE_IDLE, 1'b0);
      run_ticks(1);
      send_word(slpg_pkg::ACT_SET, slpg_pkg::MODE_BLOCKED, 1'b1);
      run_ticks(1);
    end
  endtask

  // blink edges: both blocked flashes and the complete on/off split
  task automatic test_timed_patterns();
    write_brightness(8'd255);
    send_word(slpg_pkg::ACT_SET, slpg_pkg::MODE_BLOCKED, 1'b0);
    run_ticks(270);
    send_word(slpg_pkg::ACT_SET, slpg_pkg::MODE_COMPLETE, 1'b0);
    run_ticks(230);
  endtask

  // mixed random traffic over four levels, mostly single ticks
  task automatic test_random_traffic();
    logic [7:0]  lvl;
    logic [2:0]  md;
    int unsigned sent;
    int unsigned pick;
    int unsigned run_len;
    sent = 0;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       lvl = 8'd255;
        1:       lvl = 8'd1;
        2:       lvl = 8'($urandom_range(2, 254));
        default: lvl = 8'd64;
      endcase
      write_brightness(lvl);
      // last stretch runs with no gaps or stalls
      if (p == 3) idle_on = 1'b0;
      do begin
        pick = $urandom_range(0, 99);
        md   = 3'($urandom_range(0, 7));
        if (pick < 8) begin
          send_word(slpg_pkg::ACT_SET, md, 1'($urandom_range(0, 1)));
          sent++;
        end else if (pick < 12) begin
          send_word(slpg_pkg::ACT_ACTIVITY, md, 1'($urandom_range(0, 1)));
          sent++;
        end else if (pick < 16) begin
          send_word(slpg_pkg::ACT_LINK, md, 1'($urandom_range(0, 1)));
          sent++;
        end else if (pick < 22) begin
          run_len = $urandom_range(1, 20);
          send_word(slpg_pkg::ACT_SET, 3'($urandom_range(0, 5)), 1'($urandom_range(0, 1)));
          run_ticks(run_len);
          sent += run_len + 1;
        end else begin
          run_ticks(1);
          sent++;
        end
      end while (sent < (p + 1) * RANDOM_WORDS / 4);
    end
  endtask

  // ---------------------------------------------------------------- checking
  // output side stalls in random bursts
  always @(posedge clk) begin
    if (stall_left > 0)
      stall_left--;
    else if (idle_on && $urandom_range(0, 9) == 0)
      stall_left = $urandom_range(1, 11);
    m_axis_tready <= (stall_left == 0);
  end

  // compare each emitted word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_colors.size() == 0) begin
        report_mismatch($sformatf("unexpected word %012h", m_axis_tdata));
      end else begin
        want_colors = expected_colors.pop_front();
        if (m_axis_tdata[23:0] !== want_colors[23:0])
          report_mismatch($sformatf("first_color got %06h expected %06h",
                                    m_axis_tdata[23:0], want_colors[23:0]));
        if (m_axis_tdata[47:24] !== want_colors[47:24])
          report_mismatch($sformatf("second_color got %06h expected %06h",
                                    m_axis_tdata[47:24], want_colors[47:24]));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_directed();
    test_brightness_levels();
    test_timed_patterns();
    test_random_traffic();
    settle_block();
    if (err_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== status_light_pattern_generator.f =====
rtl/slpg_pkg.sv
rtl/slpg_ctrl.sv
rtl/slpg_datapath.sv
rtl/status_light_pattern_generator.sv
tb/sv/status_light_pattern_generator_test.sv
